// ===== hdl/tmcr_pkg.sv =====
// ----------------------------------------------------------------------------
// tmcr_pkg: shared types and constants
// Sizes, reset values, action and register codes, and the queue item layout
// for the text-mode character renderer.
// ----------------------------------------------------------------------------
package tmcr_pkg;

  localparam int MAX_COLUMNS = 64;
  localparam int MAX_ROWS    = 32;

  localparam int COLS_W = 7;
  localparam int ROWS_W = 6;
  localparam int RGB_W  = 24;
  localparam int POS_W  = 10;   // raster x / y
  localparam int DIM_W  = 11;   // frame width / height in pixels
  localparam int MEM_AW = 11;   // text and font store address
  localparam int MEM_DEPTH = 1 << MEM_AW;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam int IN_DATA_W = 40;

  localparam logic [COLS_W-1:0] COLS_RESET = COLS_W'(36);
  localparam logic [ROWS_W-1:0] ROWS_RESET = ROWS_W'(14);
  localparam logic [RGB_W-1:0]  FG_RESET   = 24'h68ffbb;
  localparam logic [RGB_W-1:0]  BG_RESET   = 24'h000000;

  localparam logic [7:0] SPACE_BYTE = 8'h20;
  localparam logic [6:0] CODE_NUL   = 7'h00;
  localparam logic [6:0] CODE_SPACE = 7'h20;

  typedef enum logic [1:0] {
    ACT_TEXT  = 2'd0,
    ACT_GLYPH = 2'd1,
    ACT_PIXEL = 2'd2,
    ACT_NONE  = 2'd3
  } act_t;

  typedef enum logic [1:0] {
    REG_COLUMNS = 2'd0,
    REG_ROWS    = 2'd1,
    REG_FG      = 2'd2,
    REG_BG      = 2'd3
  } reg_idx_t;

  typedef struct packed {
    act_t              kind;
    logic [MEM_AW-1:0] addr;   // text cell or font row address
    logic [7:0]        data;   // cell byte or glyph bits
    logic [2:0]        px;     // glyph column of a pixel
    logic [3:0]        py;     // glyph row of a pixel
    logic              eol;
    logic              eof;
  } q_item_t;

endpackage

// ===== hdl/tmcr_front.sv =====
// ----------------------------------------------------------------------------
// tmcr_front: input side
// Accepts items, keeps the raster position and turns each item other than a
// no-action item into a queue entry with its store address already worked out.
// ----------------------------------------------------------------------------
module tmcr_front (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [1:0]                          in_tuser,  // action
  input  logic [tmcr_pkg::IN_DATA_W-1:0]      in_tdata,
  input  logic [tmcr_pkg::COLS_W-1:0]         text_columns,
  input  logic [tmcr_pkg::ROWS_W-1:0]         text_rows,
  input  logic                                clr_busy,
  input  logic                                q_full,
  output logic                                push,
  output tmcr_pkg::q_item_t                   push_item
);
  import tmcr_pkg::*;

  logic [COLS_W-1:0] cols;
  logic [ROWS_W-1:0] rows;
  logic [POS_W-1:0]  x_r, x_nxt;
  logic [POS_W-1:0]  y_r, y_nxt;

  logic [DIM_W-1:0]  width, height;
  logic              wrap_x;
  logic [POS_W-1:0]  xe, ye;
  logic [DIM_W-1:0]  y1;
  logic              eol, eof;
  logic [11:0]       row_base;
  logic [MEM_AW-1:0] cell_addr;
  logic              accept;
  act_t              act;

  logic [10:0] f_cell_index;
  logic [7:0]  f_cell_byte;
  logic [6:0]  f_glyph_code;
  logic [3:0]  f_glyph_row;
  logic [7:0]  f_glyph_bits;

  assign f_cell_index = in_tdata[10:0];
  assign f_cell_byte  = in_tdata[18:11];
  assign f_glyph_code = in_tdata[25:19];
  assign f_glyph_row  = in_tdata[29:26];
  assign f_glyph_bits = in_tdata[37:30];

  assign act       = act_t'(in_tuser);
  assign in_tready = !clr_busy && !q_full;
  assign accept    = in_tvalid && in_tready;
  assign push      = accept && (act != ACT_NONE);

  // clamped sizes, taken straight from the registers
  always_comb begin
    if (text_columns == '0) cols = COLS_W'(1);
    else if (text_columns > COLS_W'(MAX_COLUMNS)) cols = COLS_W'(MAX_COLUMNS);
    else cols = text_columns;
    if (text_rows == '0) rows = ROWS_W'(1);
    else if (text_rows > ROWS_W'(MAX_ROWS)) rows = ROWS_W'(MAX_ROWS);
    else rows = text_rows;
  end

  assign width  = {cols, 4'b0000};
  assign height = {rows, 5'b00000};

  always_comb begin
    wrap_x = {1'b0, x_r} >= width;
    xe     = wrap_x ? '0 : x_r;
    y1     = wrap_x ? ({1'b0, y_r} + DIM_W'(1)) : {1'b0, y_r};
    ye     = (y1 >= height) ? '0 : y1[POS_W-1:0];
    eol    = {1'b0, xe} == (width - DIM_W'(1));
    eof    = eol && ({1'b0, ye} == (height - DIM_W'(1)));
    row_base  = {7'b0, ye[9:5]} * {5'b0, cols};
    cell_addr = MEM_AW'({5'b0, xe[9:4]}) + row_base[MEM_AW-1:0];
  end

  always_comb begin
    x_nxt = x_r;
    y_nxt = y_r;
    if (accept && act == ACT_PIXEL) begin
      if (eol) begin
        x_nxt = '0;
        y_nxt = eof ? '0 : (ye + POS_W'(1));
      end else begin
        x_nxt = xe + POS_W'(1);
        y_nxt = ye;
      end
    end
  end

  always_comb begin
    push_item      = '0;
    push_item.kind = act;
    case (act)
      ACT_TEXT: begin
        push_item.addr = f_cell_index;
        push_item.data = f_cell_byte;
      end
      ACT_GLYPH: begin
        push_item.addr = {f_glyph_code, f_glyph_row};
        push_item.data = f_glyph_bits;
      end
      ACT_PIXEL: begin
        push_item.addr = cell_addr;
        push_item.px   = xe[3:1];
        push_item.py   = ye[4:1];
        push_item.eol  = eol;
        push_item.eof  = eof;
      end
      default: push_item.kind = ACT_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_r    <= '0;
      y_r    <= '0;
    end else begin
      x_r    <= x_nxt;
      y_r    <= y_nxt;
    end
  end

endmodule

// ===== hdl/tmcr_queue.sv =====
// ----------------------------------------------------------------------------
// tmcr_queue: item queue
// Short FIFO between the input side and the store pipeline.
// ----------------------------------------------------------------------------
module tmcr_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  tmcr_pkg::q_item_t   push_item,
  output logic                full,
  input  logic                pop,
  output logic                head_vld,
  output tmcr_pkg::q_item_t   head
);
  import tmcr_pkg::*;

  q_item_t           slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]   cnt_r, cnt_nxt;
  logic              do_pop;

  assign full     = cnt_r == (QPTR_W+1)'(QUEUE_DEPTH);
  assign head_vld = cnt_r != '0;
  assign head     = slot_r[rd_ptr_r];
  assign do_pop   = pop && head_vld;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + QPTR_W'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r + (QPTR_W+1)'(push) - (QPTR_W+1)'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (push) slot_r[wr_ptr_r] <= push_item;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

// ===== hdl/tmcr_back.sv =====
// ----------------------------------------------------------------------------
// tmcr_back: store pipeline
// Text store access, font store access, colour select and output register.
// Also runs the clearing pass that fills the text store with spaces.
// ----------------------------------------------------------------------------
module tmcr_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          head_vld,
  input  tmcr_pkg::q_item_t             head,
  output logic                          pop,
  input  logic [tmcr_pkg::RGB_W-1:0]    foreground_rgb,
  input  logic [tmcr_pkg::RGB_W-1:0]    background_rgb,
  output logic                          clr_busy,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [tmcr_pkg::RGB_W-1:0]    out_tdata,  // pixel_rgb
  output logic                          out_tlast,  // end_of_line
  output logic                          out_tuser   // end_of_frame
);
  import tmcr_pkg::*;

  logic [7:0] text_mem [MEM_DEPTH];
  logic [7:0] font_mem [MEM_DEPTH];

  logic              clr_busy_r;
  logic [MEM_AW-1:0] clr_cnt_r;

  logic              adv;
  logic [7:0]        text_q_r;
  logic [7:0]        font_q_r;

  logic              b_vld_r;
  q_item_t           b_item_r;
  logic [MEM_AW-1:0] b_font_addr;

  logic              c_vld_r;
  logic [7:0]        c_cell_r;
  logic [2:0]        c_px_r;
  logic              c_eol_r, c_eof_r;
  logic              c_blank, c_bit;
  logic [RGB_W-1:0]  c_on, c_off, c_rgb;

  logic              out_vld_r;
  logic [RGB_W-1:0]  out_rgb_r;
  logic              out_eol_r, out_eof_r;

  // whole pipeline moves together while the output register can take an item
  assign adv      = !out_vld_r || out_tready;
  assign pop      = adv && head_vld;
  assign clr_busy = clr_busy_r;

  // text store: clearing pass, cell writes and cell reads
  always_ff @(posedge clk) begin
    if (clr_busy_r) text_mem[clr_cnt_r] <= SPACE_BYTE;
    else if (pop && head.kind == ACT_TEXT) text_mem[head.addr] <= head.data;
    if (pop) text_q_r <= text_mem[head.addr];
  end

  assign b_font_addr = (b_item_r.kind == ACT_GLYPH) ? b_item_r.addr
                                                    : {text_q_r[6:0], b_item_r.py};

  // font store: same stage for writes and reads keeps them in item order
  always_ff @(posedge clk) begin
    if (adv && b_vld_r && b_item_r.kind == ACT_GLYPH) font_mem[b_font_addr] <= b_item_r.data;
    if (adv) font_q_r <= font_mem[b_font_addr];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b_item_r <= head;
      c_cell_r <= text_q_r;
      c_px_r   <= b_item_r.px;
      c_eol_r  <= b_item_r.eol;
      c_eof_r  <= b_item_r.eof;
      if (c_vld_r) begin
        out_rgb_r <= c_rgb;
        out_eol_r <= c_eol_r;
        out_eof_r <= c_eof_r;
      end
    end
  end

  always_comb begin
    c_blank = (c_cell_r[6:0] == CODE_NUL) || (c_cell_r[6:0] == CODE_SPACE);
    c_on    = c_cell_r[7] ? background_rgb : foreground_rgb;
    c_off   = c_cell_r[7] ? foreground_rgb : background_rgb;
    c_bit   = font_q_r[~c_px_r];   // bit 7 is the leftmost pixel
    c_rgb   = (!c_blank && c_bit) ? c_on : c_off;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_cnt_r  <= '0;
      b_vld_r    <= 1'b0;
      c_vld_r    <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      if (clr_busy_r) begin
        clr_cnt_r <= clr_cnt_r + MEM_AW'(1);
        if (clr_cnt_r == MEM_AW'(MEM_DEPTH - 1)) clr_busy_r <= 1'b0;
      end
      if (adv) begin
        b_vld_r   <= head_vld;
        c_vld_r   <= b_vld_r && (b_item_r.kind == ACT_PIXEL);
        out_vld_r <= c_vld_r;
      end
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_rgb_r;
  assign out_tlast  = out_eol_r;
  assign out_tuser  = out_eof_r;

endmodule

// ===== hdl/text_mode_character_renderer_unit.sv =====
// ----------------------------------------------------------------------------
// text_mode_character_renderer_unit: text-mode character generator
// Renders a text screen from a text store and a 128-glyph font, one pixel
// per pixel request, with 2x2 pixel doubling.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : items. in_tuser selects the action: write a text cell, write a
//           glyph row, emit the next pixel in raster order, or do nothing.
//   out_* : one item per pixel request: colour in out_tdata, end of scan
//           line on out_tlast, end of frame on out_tuser.
//   cfg_* : register writes (columns, rows, foreground, background); write
//           only while no items are in flight.
//   Throughput is one item per cycle unless out_tready is low or a clear runs.
//   A pixel passes the queue, text store read, font store read and output register.
//   After reset the text store is filled with spaces, one cell a cycle; in_tready
//   stays low until its 2048 cells are written; register writes are taken then.
//   The font store is not cleared: load every glyph before it is shown.
//   If out_tready is low the pipeline holds, the 4-entry queue fills and
//   in_tready then drops; nothing is lost.
// ----------------------------------------------------------------------------
module text_mode_character_renderer_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [1:0]  in_tuser,   // action
  input  logic [39:0] in_tdata,   // cell_index, cell_byte, glyph_code, glyph_row, glyph_bits
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // pixel_rgb
  output logic        out_tlast,  // end_of_line
  output logic        out_tuser,  // end_of_frame
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [23:0] cfg_wdata
);
  import tmcr_pkg::*;

  logic [COLS_W-1:0] text_columns_r;
  logic [ROWS_W-1:0] text_rows_r;
  logic [RGB_W-1:0]  fg_rgb_r;
  logic [RGB_W-1:0]  bg_rgb_r;

  logic    clr_busy;
  logic    q_full;
  logic    push;
  q_item_t push_item;
  logic    pop;
  logic    head_vld;
  q_item_t head;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      text_columns_r <= COLS_RESET;
      text_rows_r    <= ROWS_RESET;
      fg_rgb_r       <= FG_RESET;
      bg_rgb_r       <= BG_RESET;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_COLUMNS: text_columns_r <= cfg_wdata[COLS_W-1:0];
        REG_ROWS:    text_rows_r    <= cfg_wdata[ROWS_W-1:0];
        REG_FG:      fg_rgb_r       <= cfg_wdata;
        REG_BG:      bg_rgb_r       <= cfg_wdata;
        default: ;
      endcase
    end
  end

  tmcr_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tuser     (in_tuser),
    .in_tdata     (in_tdata),
    .text_columns (text_columns_r),
    .text_rows    (text_rows_r),
    .clr_busy     (clr_busy),
    .q_full       (q_full),
    .push         (push),
    .push_item    (push_item)
  );

  tmcr_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (pop),
    .head_vld  (head_vld),
    .head      (head)
  );

  tmcr_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head_vld       (head_vld),
    .head           (head),
    .pop            (pop),
    .foreground_rgb (fg_rgb_r),
    .background_rgb (bg_rgb_r),
    .clr_busy       (clr_busy),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .out_tlast      (out_tlast),
    .out_tuser      (out_tuser)
  );

  // end of frame is always also end of line
  a_eof_is_eol: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tlast)
    else $error("end of frame without end of line");

  // reset empties the output register
  a_reset_flush: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid straight after reset");

  // nothing goes in or comes out during the clearing pass
  a_clear_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy |-> !in_tready && !out_tvalid)
    else $error("traffic during text store clear");

endmodule
